@@ rtl/hrhs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hrhs_pkg;

    // Item kinds on the request side
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_FAIL  = 2'd2,
        KIND_START = 2'd3
    } t_kind;

    // Parse phase, one-hot
    typedef enum logic [2:0] {
        PH_DONE   = 3'b001,
        PH_HEADER = 3'b010,
        PH_BODY   = 3'b100
    } t_phase;

    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int PREFIX_LAST      = 3;   // last position of "HTTP"
    localparam int SPACE_WINDOW     = 16;  // first space must sit below this position
    localparam int STATUS_MIN_BYTES = 12;  // bytes needed before the status is taken
    localparam int STATUS_DIGITS    = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic        outcome;
        logic [9:0]  http_status;
        logic [10:0] body_offset;
        logic [10:0] body_length;
    } t_out_item;

    // Classified item, front to back
    typedef struct packed {
        t_kind      kind;
        logic       is_h;
        logic       is_t;
        logic       is_p;
        logic       is_space;
        logic       is_cr;
        logic       is_lf;
        logic       is_digit;
        logic [3:0] digit;
    } t_class;

endpackage

`default_nettype wire

@@ rtl/http_response_header_scanner_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// HTTP response header scanner.
// Request channel (push/full, i_item): one transfer per event. kind selects a
// data byte, remote close, error/timeout, or start of a new response.
// Result channel (o_result/empty/pop): one transfer per response, produced by
// a close or error/timeout while a response is open. outcome 0 carries the
// status code and the body offset/length; outcome 1 is failure, all zeros.
// Path: a request waits in the request queue until the parse engine takes it,
// which it does whenever the result queue has room; any result goes straight
// into the result queue and shows on o_result with empty low.
// Throughput: one request per cycle while the result queue has room; the
// parse engine updates its state once per byte, which sets the rate.
// Reset (synchronous, active low) empties both queues and leaves the scanner
// with no open response: nothing is reported until a start request.
// When the receiver holds off pop, the two-entry result queue fills, the
// engine pauses, the two-entry request queue fills and full goes high.
// No request or result is dropped.

module http_response_header_scanner_core #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  hrhs_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output hrhs_pkg::t_out_item o_result
);

    import hrhs_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    // front -> request queue
    logic      q_push;
    logic      q_full;
    t_class    q_in;
    // request queue -> engine
    t_class    q_out;
    logic      q_empty;
    logic      q_pop;
    // engine -> result queue
    logic      res_push;
    logic      res_full;
    t_out_item res_item;

    hrhs_front u_front (
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_item (q_in)
    );

    hrhs_fifo #(
        .WIDTH ($bits(t_class)),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    hrhs_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (q_out),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_result   (res_item)
    );

    hrhs_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_item),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );

    // engine never produces a result the result queue cannot take
    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_push && res_full))
        else $error("result produced while result queue full");

    // failure results carry no status or body
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.outcome) |->
        (o_result.http_status == '0 && o_result.body_offset == '0 &&
         o_result.body_length == '0))
        else $error("failure result with nonzero fields");

    // success always has a positive status
    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.outcome) |-> (o_result.http_status != '0))
        else $error("success result with zero status");

    // engine only consumes a request when the result queue has room
    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (!q_empty && !res_full))
        else $error("request consumed without result room");

endmodule

`default_nettype wire

@@ rtl/hrhs_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hrhs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/hrhs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hrhs_front (
    input  logic              i_push,
    input  hrhs_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_q_full,
    output logic              o_q_push,
    output hrhs_pkg::t_class  o_q_item
);

    import hrhs_pkg::*;

    logic [7:0] b;

    assign b        = i_item.data_byte;
    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

    // Per-byte character classes; position-dependent checks stay in the back end
    always_comb begin
        o_q_item          = '0;
        o_q_item.kind     = t_kind'(i_item.kind);
        o_q_item.is_h     = (b == CHAR_H);
        o_q_item.is_t     = (b == CHAR_T);
        o_q_item.is_p     = (b == CHAR_P);
        o_q_item.is_space = (b == CHAR_SPACE);
        o_q_item.is_cr    = (b == CHAR_CR);
        o_q_item.is_lf    = (b == CHAR_LF);
        o_q_item.is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        o_q_item.digit    = 4'(b - CHAR_ZERO);
    end

endmodule

`default_nettype wire

@@ rtl/hrhs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hrhs_back #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hrhs_pkg::t_class    i_item,
    input  logic                i_empty,
    output logic                o_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output hrhs_pkg::t_out_item o_result
);

    import hrhs_pkg::*;

    localparam int CW = $clog2(BUFFER_BYTES + 1);

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_count, n_count;
    logic          r_pok, n_pok;
    logic          r_space_found, n_space_found;
    logic [9:0]    r_digit, n_digit;
    logic [1:0]    r_digits, n_digits;
    logic          r_status_valid, n_status_valid;
    logic [9:0]    r_status, n_status;
    logic [1:0]    r_term, n_term;
    logic [CW-1:0] r_hdr_end, n_hdr_end;

    always_comb begin
        logic v_pok;
        logic v_hit;

        n_phase        = r_phase;
        n_count        = r_count;
        n_pok          = r_pok;
        n_space_found  = r_space_found;
        n_digit        = r_digit;
        n_digits       = r_digits;
        n_status_valid = r_status_valid;
        n_status       = r_status;
        n_term         = r_term;
        n_hdr_end      = r_hdr_end;
        v_pok          = r_pok;
        v_hit          = 1'b0;
        o_res_push     = 1'b0;
        o_result       = '0;
        o_pop          = !i_empty && !i_res_full;

        if (o_pop) begin
            unique case (i_item.kind)
                KIND_START: begin
                    n_phase        = PH_HEADER;
                    n_count        = '0;
                    n_pok          = 1'b0;
                    n_space_found  = 1'b0;
                    n_digit        = '0;
                    n_digits       = '0;
                    n_status_valid = 1'b0;
                    n_status       = '0;
                    n_term         = '0;
                    n_hdr_end      = '0;
                end
                KIND_DATA: begin
                    if (r_phase != PH_DONE && r_count < CW'(BUFFER_BYTES)) begin
                        n_count = r_count + 1'b1;

                        // "HTTP" prefix
                        priority if (r_count == '0) begin
                            v_pok = i_item.is_h;
                        end else if (r_count == CW'(PREFIX_LAST)) begin
                            v_pok = r_pok && i_item.is_p;
                        end else if (r_count < CW'(PREFIX_LAST)) begin
                            v_pok = r_pok && i_item.is_t;
                        end else begin
                            v_pok = r_pok;
                        end

                        // status digits follow the first space
                        if (r_space_found) begin
                            if (r_digits != 2'(STATUS_DIGITS)) begin
                                if (i_item.is_digit) begin
                                    n_digit  = 10'(r_digit * 10'd10) + 10'(i_item.digit);
                                    n_digits = r_digits + 1'b1;
                                end else begin
                                    v_pok = 1'b0;
                                end
                            end
                        end else if (r_count < CW'(SPACE_WINDOW) && i_item.is_space) begin
                            n_space_found = 1'b1;
                        end
                        n_pok = v_pok;

                        if (r_phase == PH_HEADER && !r_status_valid && v_pok &&
                            n_digits == 2'(STATUS_DIGITS) &&
                            n_count >= CW'(STATUS_MIN_BYTES)) begin
                            n_status_valid = 1'b1;
                            n_status       = n_digit;
                        end

                        // CR LF CR LF search
                        if (r_hdr_end == '0) begin
                            v_hit = r_term[0] ? i_item.is_lf : i_item.is_cr;
                            if (v_hit) begin
                                if (r_term == 2'd3) begin
                                    n_term    = '0;
                                    n_hdr_end = n_count;
                                    n_phase   = PH_BODY;
                                end else begin
                                    n_term = r_term + 1'b1;
                                end
                            end else begin
                                n_term = i_item.is_cr ? 2'd1 : 2'd0;
                            end
                        end
                    end
                end
                KIND_CLOSE, KIND_FAIL: begin
                    if (r_phase != PH_DONE) begin
                        n_phase    = PH_DONE;
                        o_res_push = 1'b1;
                        if (i_item.kind == KIND_CLOSE && r_count != '0 &&
                            r_status_valid && r_status != '0) begin
                            o_result.outcome     = 1'b0;
                            o_result.http_status = r_status;
                            if (r_hdr_end != '0 && r_hdr_end < r_count) begin
                                o_result.body_offset = 11'(r_hdr_end);
                                o_result.body_length = 11'(r_count - r_hdr_end);
                            end
                        end else begin
                            o_result.outcome = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_DONE;
            r_count        <= '0;
            r_pok          <= 1'b0;
            r_space_found  <= 1'b0;
            r_digit        <= '0;
            r_digits       <= '0;
            r_status_valid <= 1'b0;
            r_status       <= '0;
            r_term         <= '0;
            r_hdr_end      <= '0;
        end else begin
            r_phase        <= n_phase;
            r_count        <= n_count;
            r_pok          <= n_pok;
            r_space_found  <= n_space_found;
            r_digit        <= n_digit;
            r_digits       <= n_digits;
            r_status_valid <= n_status_valid;
            r_status       <= n_status;
            r_term         <= n_term;
            r_hdr_end      <= n_hdr_end;
        end
    end

endmodule

`default_nettype wire
